/* rtl/core/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Action codes, register address decodes, bank constants and the state record.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // action codes carried in tuser
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CPU_Q = 2'd2;
  localparam logic [1:0] ACT_PAT_Q = 2'd3;

  // scrambled register addresses
  localparam logic [15:0] ADDR_PAT_LO   = 16'hB000;
  localparam logic [15:0] ADDR_PAT_HI   = 16'hE003;
  localparam logic [15:0] ADDR_PRG_0    = 16'h8000;
  localparam logic [15:0] ADDR_PRG_1    = 16'hA000;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
  localparam logic [15:0] ADDR_SWAP     = 16'h9001;
  localparam logic [15:0] ADDR_IRQ_LO   = 16'hF000;
  localparam logic [15:0] ADDR_IRQ_HI   = 16'hF002;
  localparam logic [15:0] ADDR_IRQ_EN_A = 16'hF001;
  localparam logic [15:0] ADDR_IRQ_EN_B = 16'hF003;

  // pattern bank index offset (first pattern register page)
  localparam logic [2:0] PAT_IDX_OFS = 3'd6;

  localparam logic [7:0] IRQ_FIRE_CNT  = 8'd237;
  localparam logic [7:0] IRQ_ACK_SUB   = 8'd8;
  localparam logic [7:0] PRG_PENULT    = 8'd254;
  localparam logic [7:0] PRG_LAST      = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic        visible_line;
  } cbm_item_t;

  typedef struct packed {
    logic [7:0]      prg_first;
    logic [7:0]      prg_second;
    logic            mirror_sel;
    logic [1:0]      swap_mode;
    logic [7:0][7:0] pat_banks;
    logic [7:0]      irq_cnt;
    logic            irq_en;
    logic            irq_pend;
  } cbm_state_t;

endpackage

/* rtl/core/cbm_state.sv */
// ----------------------------------------------------------------------------
// cbm_state: mapper register file and scanline counter
// Decode CPU writes, advance the IRQ counter on ticks while enabled, hold all mapper state.
// ----------------------------------------------------------------------------
module cbm_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  cbm_pkg::cbm_item_t item_i,
  output cbm_pkg::cbm_state_t state_o,
  output cbm_pkg::cbm_state_t next_o
);

  cbm_pkg::cbm_state_t state_q, state_d;
  logic [15:0] scr;
  logic [2:0]  pat_idx;
  logic [7:0]  cnt_inc;
  logic        pat_hit;

  // fold address bits 3:2 onto bits 1:0, keep the top nibble
  assign scr     = {item_i.address[15:12], 10'd0,
                    item_i.address[1:0] | item_i.address[3:2]};
  assign pat_hit = (scr >= cbm_pkg::ADDR_PAT_LO) && (scr <= cbm_pkg::ADDR_PAT_HI);
  assign pat_idx = ({scr[13:12], 1'b0} - cbm_pkg::PAT_IDX_OFS) | {2'b00, scr[0]};
  assign cnt_inc = state_q.irq_cnt + 8'd1;

  always_comb begin
    state_d = state_q;
    if (upd_i) begin
      case (item_i.action)
        cbm_pkg::ACT_WRITE: begin
          if (pat_hit) begin
            if (scr[1]) begin
              state_d.pat_banks[pat_idx][7:4] = item_i.data[3:0];
            end else begin
              state_d.pat_banks[pat_idx][3:0] = item_i.data[3:0];
            end
          end else begin
            case (scr)
              cbm_pkg::ADDR_PRG_0:  state_d.prg_first  = item_i.data;
              cbm_pkg::ADDR_PRG_1:  state_d.prg_second = item_i.data;
              cbm_pkg::ADDR_MIRROR: state_d.mirror_sel = item_i.data[0];
              cbm_pkg::ADDR_SWAP:   state_d.swap_mode  = item_i.data[1:0];
              cbm_pkg::ADDR_IRQ_LO: state_d.irq_cnt[3:0] = item_i.data[3:0];
              cbm_pkg::ADDR_IRQ_HI: state_d.irq_cnt[7:4] = item_i.data[3:0];
              cbm_pkg::ADDR_IRQ_EN_A, cbm_pkg::ADDR_IRQ_EN_B: begin
                state_d.irq_en   = item_i.data[1];
                state_d.irq_pend = 1'b0;
                if (item_i.visible_line) begin
                  state_d.irq_cnt = state_q.irq_cnt - cbm_pkg::IRQ_ACK_SUB;
                end
              end
              default: ;
            endcase
          end
        end
        cbm_pkg::ACT_TICK: begin
          if (state_q.irq_en) begin
            state_d.irq_cnt = cnt_inc;
            if (cnt_inc == cbm_pkg::IRQ_FIRE_CNT) begin
              state_d.irq_pend = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;
  assign next_o  = state_d;

endmodule

/* rtl/core/cbm_xlate.sv */
// ----------------------------------------------------------------------------
// cbm_xlate: address to bank translation
// Map CPU query addresses to 8K program banks and pattern addresses to 1K banks.
// ----------------------------------------------------------------------------
module cbm_xlate (
  input  cbm_pkg::cbm_item_t  item_i,
  input  cbm_pkg::cbm_state_t state_i,
  output logic [7:0]          bank_o
);

  logic swapped;

  assign swapped = (state_i.swap_mode != 2'd0);

  always_comb begin
    bank_o = 8'd0;
    case (item_i.action)
      cbm_pkg::ACT_CPU_Q: begin
        if (item_i.address[15]) begin
          case (item_i.address[14:13])
            2'd0:    bank_o = swapped ? cbm_pkg::PRG_PENULT : state_i.prg_first;
            2'd1:    bank_o = state_i.prg_second;
            2'd2:    bank_o = swapped ? state_i.prg_first : cbm_pkg::PRG_PENULT;
            default: bank_o = cbm_pkg::PRG_LAST;
          endcase
        end
      end
      cbm_pkg::ACT_PAT_Q: begin
        if (item_i.address[15:13] == 3'd0) begin
          bank_o = state_i.pat_banks[item_i.address[12:10]];
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/cartridge_bank_mapper_with_scanline_irq.sv */
// Pipeline: an accepted beat is held in the input register, then its result is loaded into the result register.
// Throughput: one beat per cycle while the result side is free or taking a beat; the input
//   register and result register both move in every such cycle and hold otherwise.
// Reset: rst_ni low clears all mapper state (banks, mirroring, swap mode, counter,
//   enable, pending) to zero and empties both pipeline registers.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq: cartridge mapper with scanline IRQ
// Scrambled register writes, program/pattern bank lookup and a scanline counter.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] address, [23:16] data,
                                        // [24] visible_line, [31:25] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  // result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] bank, [8] vertical_mirroring,
                                        // [9] irq_line, [15:10] zero
);

  // Input register: holds the accepted beat until the result register can load.
  logic               in_valid_q;
  cbm_pkg::cbm_item_t item_q;

  // Result register
  logic       out_valid_q;
  logic [7:0] bank_q;
  logic       vmirror_q;
  logic       irq_q;

  logic                advance;
  cbm_pkg::cbm_state_t state_cur;
  cbm_pkg::cbm_state_t state_nxt;
  logic [7:0]          bank;

  // Advance the held beat whenever the result slot is empty or being drained;
  // the state update and the result load happen on the same edge, so the next
  // beat always sees the state this one left behind.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.action       <= s_axis_tuser_i;
      item_q.address      <= s_axis_tdata_i[15:0];
      item_q.data         <= s_axis_tdata_i[23:16];
      item_q.visible_line <= s_axis_tdata_i[24];
    end
  end

  cbm_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (advance),
    .item_i  (item_q),
    .state_o (state_cur),
    .next_o  (state_nxt)
  );

  // Queries do not touch state, so lookup from the current state is exact.
  cbm_xlate u_xlate (
    .item_i  (item_q),
    .state_i (state_cur),
    .bank_o  (bank)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Mirroring and IRQ report the state after this beat's update.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      bank_q    <= bank;
      vmirror_q <= ~state_nxt.mirror_sel;
      irq_q     <= state_nxt.irq_pend;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, irq_q, vmirror_q, bank_q};

`ifndef SYNTH
  // The pending flag may only rise from an enabled scanline tick.
  a_pend_rise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_cur.irq_pend) |-> $past(advance && item_q.action == cbm_pkg::ACT_TICK))
    else $error("irq pending rose without a scanline tick");

  // Mapper state holds while no beat advances.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_cur))
    else $error("mapper state changed without an advancing beat");

  // A beat that advances always lands in the result register.
  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced beat did not produce a result");

  // Input side stalls only when a beat is held and the result slot is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");
`endif

endmodule
